>>> rtl/bccpu_pkg.sv
// package of the byte-coded cpu execute unit: opcodes, states and shared types
package bccpu_pkg;

  // instruction opcodes
  localparam logic [7:0] OP_HALT  = 8'h00;
  localparam logic [7:0] OP_ADD   = 8'h01;
  localparam logic [7:0] OP_SUB   = 8'h02;
  localparam logic [7:0] OP_MUL   = 8'h03;
  localparam logic [7:0] OP_DIV   = 8'h04;
  localparam logic [7:0] OP_LOAD  = 8'h05;
  localparam logic [7:0] OP_STORE = 8'h06;
  localparam logic [7:0] OP_MOV   = 8'h07;
  localparam logic [7:0] OP_ADDI  = 8'h09;
  localparam logic [7:0] OP_SUBI  = 8'h0A;
  localparam logic [7:0] OP_MULI  = 8'h0B;
  localparam logic [7:0] OP_DIVI  = 8'h0C;
  localparam logic [7:0] OP_MOVI  = 8'h0F;
  localparam logic [7:0] OP_BEQ   = 8'h10;
  localparam logic [7:0] OP_BNE   = 8'h11;
  localparam logic [7:0] OP_BGE   = 8'h12;
  localparam logic [7:0] OP_BLT   = 8'h13;
  localparam logic [7:0] OP_BGT   = 8'h14;
  localparam logic [7:0] OP_BLE   = 8'h15;
  localparam logic [7:0] OP_BAL   = 8'h1E;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned DIV_STEPS = 32;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV
  } alu_op_t;

  typedef struct packed {
    logic n;
    logic z;
    logic c;
    logic v;
  } flags_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] result;
    flags_t      flags;
  } alu_rsp_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RDA,
    ST_RDB,
    ST_LATB,
    ST_EXEC,
    ST_ALU,
    ST_LOAD,
    ST_STORE,
    ST_WB,
    ST_OUT
  } state_t;

endpackage

>>> rtl/bccpu_alu.sv
// shared arithmetic unit: add, subtract and multiply with a registered result, divide one bit a cycle
module bccpu_alu (
  input  logic                clk,
  input  logic                rst,
  input  bccpu_pkg::alu_req_t req,
  input  logic [31:0]         a,
  input  logic [31:0]         b,
  output bccpu_pkg::alu_rsp_t rsp
);

  logic        busy;
  logic [5:0]  cnt;
  logic [31:0] quo;
  logic [31:0] rem;
  logic [31:0] dvs;
  logic        done;
  logic [31:0] result;
  bccpu_pkg::flags_t flags;

  logic [32:0] sum;
  logic [32:0] dif;
  logic [32:0] rem_sh;
  logic [32:0] rem_try;

  // combinational sum and difference
  assign sum = {1'b0, a} + {1'b0, b};
  assign dif = {1'b0, a} - {1'b0, b};

  // one restoring divide step
  assign rem_sh  = {rem, quo[31]};
  assign rem_try = rem_sh - {1'b0, dvs};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      if (req.start) begin
        busy <= (req.op == bccpu_pkg::ALU_DIV);
        done <= (req.op != bccpu_pkg::ALU_DIV);
        cnt  <= '0;
      end else if (busy) begin
        cnt  <= cnt + 6'd1;
        busy <= (cnt != 6'(bccpu_pkg::DIV_STEPS - 1));
        done <= (cnt == 6'(bccpu_pkg::DIV_STEPS - 1));
      end else begin
        done <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      unique case (req.op)
        bccpu_pkg::ALU_ADD: begin
          result  <= sum[31:0];
          flags.n <= sum[31];
          flags.z <= (sum[31:0] == '0);
          flags.c <= sum[32];
          flags.v <= (~(a[31] ^ b[31])) & (a[31] ^ sum[31]);
        end
        bccpu_pkg::ALU_SUB: begin
          result  <= dif[31:0];
          flags.n <= dif[31];
          flags.z <= (dif[31:0] == '0);
          flags.c <= (a >= b);
          flags.v <= (a[31] ^ b[31]) & (a[31] ^ dif[31]);
        end
        bccpu_pkg::ALU_MUL: begin
          result <= a * b;
        end
        bccpu_pkg::ALU_DIV: begin
          quo <= a;
          rem <= '0;
          dvs <= b;
        end
        default: begin
          result <= '0;
        end
      endcase
    end else if (busy) begin
      if (!rem_try[32]) begin
        rem <= rem_try[31:0];
        quo <= {quo[30:0], 1'b1};
        if (cnt == 6'(bccpu_pkg::DIV_STEPS - 1)) result <= {quo[30:0], 1'b1};
      end else begin
        rem <= rem_sh[31:0];
        quo <= {quo[30:0], 1'b0};
        if (cnt == 6'(bccpu_pkg::DIV_STEPS - 1)) result <= {quo[30:0], 1'b0};
      end
    end
  end

  assign rsp.done   = done;
  assign rsp.result = result;
  assign rsp.flags  = flags;

endmodule

>>> rtl/bccpu_regfile.sv
// register file memory with per-entry valid bits so reset reads as zero
module bccpu_regfile #(
  parameter int unsigned REG_COUNT = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  raddr,
  output logic [31:0] rdata,
  input  logic        we,
  input  logic [7:0]  waddr,
  input  logic [31:0] wdata
);

  localparam int unsigned RW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

  logic [31:0]          mem [REG_COUNT];
  logic [REG_COUNT-1:0] valid;
  logic [31:0]          mem_q;
  logic                 ok_q;
  logic                 rd_in;
  logic                 wr_in;

  assign rd_in = ({1'b0, raddr} < 9'(REG_COUNT));
  assign wr_in = ({1'b0, waddr} < 9'(REG_COUNT));

  // write port
  always_ff @(posedge clk) begin
    if (we && wr_in) mem[waddr[RW-1:0]] <= wdata;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we && wr_in) begin
      valid[waddr[RW-1:0]] <= 1'b1;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    mem_q <= mem[raddr[RW-1:0]];
    ok_q  <= rd_in && valid[raddr[RW-1:0]];
  end

  assign rdata = ok_q ? mem_q : '0;

endmodule

>>> rtl/bccpu_dstore.sv
// byte data store memory with a clearing sweep after reset
module bccpu_dstore #(
  parameter int unsigned DATA_BYTES = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  output logic                          clearing,
  input  logic                          we,
  input  logic [$clog2(DATA_BYTES)-1:0] waddr,
  input  logic [7:0]                    wdata,
  input  logic [$clog2(DATA_BYTES)-1:0] raddr,
  output logic [7:0]                    rdata
);

  localparam int unsigned AW = $clog2(DATA_BYTES);

  logic [7:0] mem [DATA_BYTES];
  logic [AW:0] clr_cnt;

  // clearing sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == (AW+1)'(DATA_BYTES - 1)) clearing <= 1'b0;
    end
  end

  // write port, shared with the sweep
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_cnt[AW-1:0]] <= 8'h00;
    end else if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/byte_coded_cpu_execute_unit.sv
// top level of the byte-coded cpu execute unit
// Executes one instruction or one data byte preload per input transfer and returns one
// result transfer per input. The block works on one item at a time: a 32-bit store or load
// walks the byte-wide data store one byte a cycle, and a divide uses the shared arithmetic
// unit, which retires one quotient bit a cycle. Preloads and items after halt go straight
// to the result. After reset the data store is swept to zero, one byte a cycle, and no
// input is taken until the sweep is done.
module byte_coded_cpu_execute_unit #(
  parameter int unsigned DATA_BYTES = 4096,
  parameter int unsigned REG_COUNT  = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // opcode, dest_reg, src1_reg, src2_byte, load_addr, load_byte (lowest bit up)
  input  logic [55:0] s_tdata,
  // action
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // next_pc, halted, flag_n, flag_z, flag_c, flag_v, reg_written, reg_index,
  // reg_value, store_done (lowest bit up)
  output logic [79:0] m_tdata
);

  localparam int unsigned AW = $clog2(DATA_BYTES);

  bccpu_pkg::state_t state, state_next;

  // latched item
  logic        act;
  logic [7:0]  op;
  logic [7:0]  dst;
  logic [7:0]  src1;
  logic [7:0]  src2;
  logic [11:0] ld_addr;
  logic [7:0]  ld_byte;

  // architectural state
  logic [31:0]       pc;
  bccpu_pkg::flags_t flags;
  logic              halt;

  // working registers
  logic [31:0] opa;
  logic [31:0] opb_raw;
  logic [31:0] maddr;
  logic [31:0] lword;
  logic [2:0]  cnt;
  logic        wflag;
  logic [31:0] wval;
  logic        sdone;
  logic        wr_ok;

  // unit interfaces
  logic [7:0]          rf_raddr;
  logic [31:0]         rf_rdata;
  logic                rf_we;
  logic                clearing;
  logic                ds_we;
  logic [AW-1:0]       ds_waddr;
  logic [7:0]          ds_wdata;
  logic [AW-1:0]       ds_raddr;
  logic [7:0]          ds_rdata;
  bccpu_pkg::alu_req_t alu_req;
  bccpu_pkg::alu_rsp_t alu_rsp;

  // decode helpers
  logic        is_imm;
  logic        is_alu;
  logic        div_zero;
  logic        cond;
  logic [31:0] opb;
  logic [31:0] br_off;
  logic        fits_a;
  logic        fits_b;
  logic        in_fire;
  logic        out_free;
  logic [31:0] pre_addr;

  assign in_fire  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign is_imm = (op == bccpu_pkg::OP_ADDI) || (op == bccpu_pkg::OP_SUBI) ||
                  (op == bccpu_pkg::OP_MULI) || (op == bccpu_pkg::OP_DIVI);
  assign is_alu = (op == bccpu_pkg::OP_ADD) || (op == bccpu_pkg::OP_SUB) ||
                  (op == bccpu_pkg::OP_MUL) || (op == bccpu_pkg::OP_DIV) || is_imm;
  assign opb      = is_imm ? {24'h0, src2} : opb_raw;
  assign div_zero = ((op == bccpu_pkg::OP_DIV) || (op == bccpu_pkg::OP_DIVI)) &&
                    (opb == '0);
  assign br_off   = {{22{src2[7]}}, src2, 2'b00};
  assign fits_a   = ({1'b0, opa} + 33'd4) <= 33'(DATA_BYTES);
  assign fits_b   = ({1'b0, opb_raw} + 33'd4) <= 33'(DATA_BYTES);
  assign pre_addr = {20'h0, ld_addr};

  // branch condition
  always_comb begin
    case (op)
      bccpu_pkg::OP_BEQ: cond = flags.z;
      bccpu_pkg::OP_BNE: cond = !flags.z;
      bccpu_pkg::OP_BGE: cond = (flags.n == flags.v);
      bccpu_pkg::OP_BLT: cond = (flags.n != flags.v);
      bccpu_pkg::OP_BGT: cond = !flags.z && (flags.n == flags.v);
      bccpu_pkg::OP_BLE: cond = flags.z || (flags.n != flags.v);
      bccpu_pkg::OP_BAL: cond = 1'b1;
      default:           cond = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      bccpu_pkg::ST_CLEAR: if (!clearing) state_next = bccpu_pkg::ST_IDLE;
      bccpu_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (halt || s_tuser) state_next = bccpu_pkg::ST_OUT;
          else state_next = bccpu_pkg::ST_RDA;
        end
      end
      bccpu_pkg::ST_RDA:  state_next = bccpu_pkg::ST_RDB;
      bccpu_pkg::ST_RDB:  state_next = bccpu_pkg::ST_LATB;
      bccpu_pkg::ST_LATB: state_next = bccpu_pkg::ST_EXEC;
      bccpu_pkg::ST_EXEC: begin
        if (op == bccpu_pkg::OP_HALT) state_next = bccpu_pkg::ST_OUT;
        else if (op == bccpu_pkg::OP_MOV || op == bccpu_pkg::OP_MOVI)
          state_next = bccpu_pkg::ST_WB;
        else if (is_alu) state_next = div_zero ? bccpu_pkg::ST_OUT : bccpu_pkg::ST_ALU;
        else if (op == bccpu_pkg::OP_LOAD)
          state_next = fits_a ? bccpu_pkg::ST_LOAD : bccpu_pkg::ST_WB;
        else if (op == bccpu_pkg::OP_STORE)
          state_next = fits_b ? bccpu_pkg::ST_STORE : bccpu_pkg::ST_OUT;
        else state_next = bccpu_pkg::ST_OUT;
      end
      bccpu_pkg::ST_ALU:   if (alu_rsp.done) state_next = bccpu_pkg::ST_WB;
      bccpu_pkg::ST_LOAD:  if (cnt == 3'd4) state_next = bccpu_pkg::ST_WB;
      bccpu_pkg::ST_STORE: if (cnt == 3'd3) state_next = bccpu_pkg::ST_OUT;
      bccpu_pkg::ST_WB:    state_next = bccpu_pkg::ST_OUT;
      bccpu_pkg::ST_OUT:   if (out_free) state_next = bccpu_pkg::ST_IDLE;
      default:             state_next = bccpu_pkg::ST_IDLE;
    endcase
  end

  // unit controls
  always_comb begin
    s_tready      = 1'b0;
    rf_raddr      = src1;
    rf_we         = 1'b0;
    ds_we         = 1'b0;
    ds_waddr      = pre_addr[AW-1:0];
    ds_wdata      = ld_byte;
    ds_raddr      = 32'(maddr + 32'(cnt)) >= 32'(DATA_BYTES) ? '0
                    : AW'(maddr + 32'(cnt));
    alu_req.start = 1'b0;
    alu_req.op    = bccpu_pkg::ALU_ADD;
    unique case (op)
      bccpu_pkg::OP_SUB, bccpu_pkg::OP_SUBI: alu_req.op = bccpu_pkg::ALU_SUB;
      bccpu_pkg::OP_MUL, bccpu_pkg::OP_MULI: alu_req.op = bccpu_pkg::ALU_MUL;
      bccpu_pkg::OP_DIV, bccpu_pkg::OP_DIVI: alu_req.op = bccpu_pkg::ALU_DIV;
      default:                               alu_req.op = bccpu_pkg::ALU_ADD;
    endcase
    unique case (state)
      bccpu_pkg::ST_IDLE: s_tready = 1'b1;
      bccpu_pkg::ST_RDB:  rf_raddr = (op == bccpu_pkg::OP_STORE) ? dst : src2;
      bccpu_pkg::ST_EXEC: alu_req.start = is_alu && !div_zero;
      bccpu_pkg::ST_STORE: begin
        ds_we    = 1'b1;
        ds_waddr = AW'(maddr + 32'(cnt));
        ds_wdata = opa[7:0];
      end
      bccpu_pkg::ST_WB:   rf_we = wr_ok;
      bccpu_pkg::ST_OUT:  ds_we = act && !halt && (pre_addr < 32'(DATA_BYTES));
      default: begin
      end
    endcase
  end

  assign wr_ok = wflag && ({1'b0, dst} < 9'(REG_COUNT));

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= bccpu_pkg::ST_CLEAR;
      pc       <= '0;
      flags    <= '0;
      halt     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == bccpu_pkg::ST_EXEC) begin
        if (op == bccpu_pkg::OP_HALT) halt <= 1'b1;
        else if (!is_alu && op != bccpu_pkg::OP_LOAD && op != bccpu_pkg::OP_STORE &&
                 op != bccpu_pkg::OP_MOV && op != bccpu_pkg::OP_MOVI && cond)
          pc <= pc + br_off;
        else pc <= pc + 32'd4;
      end
      if (state == bccpu_pkg::ST_ALU && alu_rsp.done &&
          (alu_req.op == bccpu_pkg::ALU_ADD || alu_req.op == bccpu_pkg::ALU_SUB))
        flags <= alu_rsp.flags;
      if (state == bccpu_pkg::ST_OUT && out_free) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      act     <= s_tuser;
      op      <= s_tdata[7:0];
      dst     <= s_tdata[15:8];
      src1    <= s_tdata[23:16];
      src2    <= s_tdata[31:24];
      ld_addr <= s_tdata[43:32];
      ld_byte <= s_tdata[51:44];
      wflag   <= 1'b0;
      wval    <= '0;
      sdone   <= 1'b0;
    end
    unique case (state)
      bccpu_pkg::ST_RDB:  opa <= rf_rdata;
      bccpu_pkg::ST_LATB: opb_raw <= rf_rdata;
      bccpu_pkg::ST_EXEC: begin
        cnt <= '0;
        if (op == bccpu_pkg::OP_MOV || op == bccpu_pkg::OP_MOVI) begin
          wflag <= 1'b1;
          wval  <= {24'h0, src2};
        end else if (op == bccpu_pkg::OP_LOAD) begin
          maddr <= opa;
          if (!fits_a) begin
            wflag <= 1'b1;
            wval  <= '0;
          end
        end else if (op == bccpu_pkg::OP_STORE) begin
          maddr <= opb_raw;
          sdone <= fits_b;
        end
      end
      bccpu_pkg::ST_ALU: begin
        if (alu_rsp.done) begin
          wflag <= 1'b1;
          wval  <= alu_rsp.result;
        end
      end
      bccpu_pkg::ST_LOAD: begin
        cnt <= cnt + 3'd1;
        if (cnt != 3'd0) lword <= {ds_rdata, lword[31:8]};
        if (cnt == 3'd4) begin
          wflag <= 1'b1;
          wval  <= {ds_rdata, lword[31:8]};
        end
      end
      bccpu_pkg::ST_STORE: begin
        cnt <= cnt + 3'd1;
        opa <= {8'h00, opa[31:8]};
      end
      bccpu_pkg::ST_WB:   wflag <= wr_ok;
      default: begin
      end
    endcase
    // result register
    if (state == bccpu_pkg::ST_OUT && out_free) begin
      m_tdata[31:0]  <= pc;
      m_tdata[32]    <= halt;
      m_tdata[33]    <= flags.n;
      m_tdata[34]    <= flags.z;
      m_tdata[35]    <= flags.c;
      m_tdata[36]    <= flags.v;
      m_tdata[37]    <= wflag;
      m_tdata[45:38] <= wflag ? dst : 8'h00;
      m_tdata[77:46] <= wflag ? wval : 32'h0;
      m_tdata[78]    <= sdone;
      m_tdata[79]    <= 1'b0;
    end
  end

  bccpu_regfile #(
    .REG_COUNT(REG_COUNT)
  ) u_regfile (
    .clk  (clk),
    .rst  (rst),
    .raddr(rf_raddr),
    .rdata(rf_rdata),
    .we   (rf_we),
    .waddr(dst),
    .wdata(wval)
  );

  bccpu_dstore #(
    .DATA_BYTES(DATA_BYTES)
  ) u_dstore (
    .clk     (clk),
    .rst     (rst),
    .clearing(clearing),
    .we      (ds_we),
    .waddr   (ds_waddr),
    .wdata   (ds_wdata),
    .raddr   (ds_raddr),
    .rdata   (ds_rdata)
  );

  bccpu_alu u_alu (
    .clk(clk),
    .rst(rst),
    .req(alu_req),
    .a  (opa),
    .b  (opb),
    .rsp(alu_rsp)
  );

  // halt mark never clears once set
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst) halt |=> halt)
    else $error("halt mark cleared");

  // no input taken during the clearing sweep
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_tready)
    else $error("input accepted while clearing");

  // a result never reports both a register write and a store
  a_write_or_store: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[37] && m_tdata[78]))
    else $error("register write and store in one result");

  // the shared unit is only started from the execute step
  a_alu_start: assert property (@(posedge clk) disable iff (rst)
    alu_req.start |-> state == bccpu_pkg::ST_EXEC)
    else $error("arithmetic unit started outside execute");

endmodule

>>> tb/tb_top.sv
// self-checking testbench for the byte-coded cpu execute unit
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned MEM_BYTES  = 4096;
  localparam int unsigned NUM_REGS   = 256;
  localparam int unsigned IDLE_LIMIT = 30000;

  typedef struct {
    logic        act;
    logic [7:0]  op;
    logic [7:0]  d;
    logic [7:0]  s1;
    logic [7:0]  s2;
    logic [11:0] la;
    logic [7:0]  lb;
    bit          drain;
  } instr_item_t;

  typedef struct {
    logic [31:0] pc;
    logic        hlt;
    logic        n, z, c, v;
    logic        wr;
    logic [7:0]  widx;
    logic [31:0] wval;
    logic        st;
  } exec_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;

  byte_coded_cpu_execute_unit uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // predicted architectural state
  logic [31:0] cpu_regs [NUM_REGS];
  logic [7:0]  cpu_mem  [MEM_BYTES];
  logic [31:0] cpu_pc;
  logic        cpu_n, cpu_z, cpu_c, cpu_v, cpu_halt;

  instr_item_t  pending_instrs[$];
  exec_result_t expected_results[$];
  int errors = 0;
  int results_seen = 0;
  int idle_cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch on result %0d: %s got 0x%0h expected 0x%0h",
             results_seen, what, got, want);
    errors++;
  endtask

  function automatic bit word_in_range(input logic [31:0] addr);
    return ({1'b0, addr} + 33'd4) <= 33'(MEM_BYTES);
  endfunction

  function automatic bit cond_passes(input logic [7:0] op);
    case (op)
      bccpu_pkg::OP_BEQ: return cpu_z;
      bccpu_pkg::OP_BNE: return !cpu_z;
      bccpu_pkg::OP_BGE: return cpu_n == cpu_v;
      bccpu_pkg::OP_BLT: return cpu_n != cpu_v;
      bccpu_pkg::OP_BGT: return !cpu_z && (cpu_n == cpu_v);
      bccpu_pkg::OP_BLE: return cpu_z || (cpu_n != cpu_v);
      bccpu_pkg::OP_BAL: return 1'b1;
      default:           return 1'b0;
    endcase
  endfunction

  // executes one item on the predicted state and returns the expected result
  task automatic execute_item(input instr_item_t it, output exec_result_t r);
    logic [31:0] a, b, res, addr;
    logic [32:0] sum;
    bit advance;
    r.wr = 0; r.widx = '0; r.wval = '0; r.st = 0;
    if (!cpu_halt) begin
      if (it.act) begin
        cpu_mem[it.la] = it.lb;
      end else begin
        advance = 1;
        a = cpu_regs[it.s1];
        case (it.op)
          bccpu_pkg::OP_HALT: begin
            cpu_halt = 1;
            advance = 0;
          end
          bccpu_pkg::OP_MOV, bccpu_pkg::OP_MOVI: begin
            r.wr = 1; r.wval = {24'd0, it.s2};
          end
          bccpu_pkg::OP_ADD, bccpu_pkg::OP_ADDI: begin
            b = (it.op == bccpu_pkg::OP_ADD) ? cpu_regs[it.s2] : {24'd0, it.s2};
            sum = {1'b0, a} + {1'b0, b};
            res = sum[31:0];
            r.wr = 1; r.wval = res;
            cpu_n = res[31]; cpu_z = (res == 0); cpu_c = sum[32];
            cpu_v = ~(a[31] ^ b[31]) & (a[31] ^ res[31]);
          end
          bccpu_pkg::OP_SUB, bccpu_pkg::OP_SUBI: begin
            b = (it.op == bccpu_pkg::OP_SUB) ? cpu_regs[it.s2] : {24'd0, it.s2};
            res = a - b;
            r.wr = 1; r.wval = res;
            cpu_n = res[31]; cpu_z = (res == 0); cpu_c = (a >= b);
            cpu_v = (a[31] ^ b[31]) & (a[31] ^ res[31]);
          end
          bccpu_pkg::OP_MUL, bccpu_pkg::OP_MULI: begin
            b = (it.op == bccpu_pkg::OP_MUL) ? cpu_regs[it.s2] : {24'd0, it.s2};
            r.wr = 1; r.wval = a * b;
          end
          bccpu_pkg::OP_DIV, bccpu_pkg::OP_DIVI: begin
            b = (it.op == bccpu_pkg::OP_DIV) ? cpu_regs[it.s2] : {24'd0, it.s2};
            if (b != 0) begin
              r.wr = 1; r.wval = a / b;
            end
          end
          bccpu_pkg::OP_LOAD: begin
            res = '0;
            if (word_in_range(a))
              res = {cpu_mem[a + 3], cpu_mem[a + 2], cpu_mem[a + 1], cpu_mem[a]};
            r.wr = 1; r.wval = res;
          end
          bccpu_pkg::OP_STORE: begin
            addr = cpu_regs[it.d];
            if (word_in_range(addr)) begin
              {cpu_mem[addr + 3], cpu_mem[addr + 2], cpu_mem[addr + 1], cpu_mem[addr]} = a;
              r.st = 1;
            end
          end
          default: begin
            if (cond_passes(it.op)) begin
              cpu_pc = cpu_pc + ({{24{it.s2[7]}}, it.s2} << 2);
              advance = 0;
            end
          end
        endcase
        if (r.wr) begin
          r.widx = it.d;
          cpu_regs[it.d] = r.wval;
        end
        if (advance) cpu_pc = cpu_pc + 32'd4;
      end
    end
    r.pc = cpu_pc; r.hlt = cpu_halt;
    r.n = cpu_n; r.z = cpu_z; r.c = cpu_c; r.v = cpu_v;
  endtask

  function automatic instr_item_t rand_fields();
    instr_item_t it;
    it.act = 0; it.drain = 0;
    it.op = 8'($urandom); it.d = 8'($urandom); it.s1 = 8'($urandom);
    it.s2 = 8'($urandom); it.la = 12'($urandom); it.lb = 8'($urandom);
    return it;
  endfunction

  task automatic add_instr(input logic [7:0] op, input logic [7:0] d,
                           input logic [7:0] s1, input logic [7:0] s2);
    instr_item_t it;
    it = rand_fields();
    it.op = op; it.d = d; it.s1 = s1; it.s2 = s2;
    pending_instrs.push_back(it);
  endtask

  task automatic add_preload(input logic [11:0] la, input logic [7:0] lb);
    instr_item_t it;
    it = rand_fields();
    it.act = 1; it.la = la; it.lb = lb;
    pending_instrs.push_back(it);
  endtask

  task automatic add_drain();
    instr_item_t it;
    it = rand_fields();
    it.drain = 1;
    pending_instrs.push_back(it);
  endtask

  // sender: bursts with random gaps, prediction at each accepted transfer
  int gap_left = 0;
  int burst_left = 8;
  always @(posedge clk) begin
    exec_result_t r;
    instr_item_t it;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        it.act = s_tuser;
        {it.lb, it.la, it.s2, it.s1, it.d, it.op} = s_tdata[51:0];
        execute_item(it, r);
        expected_results.push_back(r);
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (pending_instrs.size() > 0 && pending_instrs[0].drain) begin
          s_tvalid <= 1'b0;
          if (expected_results.size() == 0) void'(pending_instrs.pop_front());
        end else if (pending_instrs.size() > 0) begin
          it = pending_instrs.pop_front();
          s_tdata <= {4'd0, it.lb, it.la, it.s2, it.s1, it.d, it.op};
          s_tuser <= it.act;
          s_tvalid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: changing stall pattern plus one long hold-off
  int rx_mode = 0;
  int rx_mode_left = 0;
  int hold_left = 0;
  bit hold_done = 0;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (!hold_done && results_seen >= 300) begin
      hold_done = 1;
      hold_left = 600;
      m_tready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_mode_left = $urandom_range(20, 200);
      end
      rx_mode_left--;
      case (rx_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= 1'($urandom);
        2: m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // result check against the oldest prediction
  always @(posedge clk) begin
    exec_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $display("unexpected result transfer 0x%0h", m_tdata);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (m_tdata[31:0] !== want.pc) report_mismatch("next_pc", m_tdata[31:0], want.pc);
        if (m_tdata[32] !== want.hlt) report_mismatch("halted", m_tdata[32], want.hlt);
        if (m_tdata[33] !== want.n) report_mismatch("flag_n", m_tdata[33], want.n);
        if (m_tdata[34] !== want.z) report_mismatch("flag_z", m_tdata[34], want.z);
        if (m_tdata[35] !== want.c) report_mismatch("flag_c", m_tdata[35], want.c);
        if (m_tdata[36] !== want.v) report_mismatch("flag_v", m_tdata[36], want.v);
        if (m_tdata[37] !== want.wr) report_mismatch("reg_written", m_tdata[37], want.wr);
        if (m_tdata[45:38] !== want.widx)
          report_mismatch("reg_index", m_tdata[45:38], want.widx);
        if (m_tdata[77:46] !== want.wval)
          report_mismatch("reg_value", m_tdata[77:46], want.wval);
        if (m_tdata[78] !== want.st) report_mismatch("store_done", m_tdata[78], want.st);
      end
      results_seen++;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("byte_coded_cpu_execute_unit verification failed");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    instr_item_t it;
    int k;
    int base;
    for (int i = 0; i < NUM_REGS; i++) cpu_regs[i] = '0;
    for (int i = 0; i < MEM_BYTES; i++) cpu_mem[i] = '0;
    cpu_pc = '0; cpu_n = 0; cpu_z = 0; cpu_c = 0; cpu_v = 0; cpu_halt = 0;

    // directed: extremes, arithmetic, move, load, store and some branch opcodes, range and zero cases
    add_instr(bccpu_pkg::OP_MOVI, 8'd1, 8'd0, 8'hFF);
    add_instr(bccpu_pkg::OP_MOV, 8'd2, 8'd0, 8'd1);
    add_instr(bccpu_pkg::OP_ADD, 8'd3, 8'd1, 8'd2);
    add_instr(bccpu_pkg::OP_SUB, 8'd4, 8'd2, 8'd1);
    add_instr(bccpu_pkg::OP_SUBI, 8'd5, 8'd2, 8'd1);
    add_instr(bccpu_pkg::OP_BEQ, 8'd0, 8'd0, 8'h80);
    add_instr(bccpu_pkg::OP_MUL, 8'd6, 8'd4, 8'd4);
    add_instr(bccpu_pkg::OP_ADDI, 8'd7, 8'd4, 8'hFF);
    add_instr(bccpu_pkg::OP_BLT, 8'd0, 8'd0, 8'h7F);
    add_instr(bccpu_pkg::OP_DIVI, 8'd8, 8'd1, 8'd0);
    add_instr(bccpu_pkg::OP_DIV, 8'd9, 8'd4, 8'd0);
    add_instr(bccpu_pkg::OP_DIVI, 8'd10, 8'd4, 8'd7);
    add_preload(12'd0, 8'hA5);
    add_preload(12'd3, 8'h81);
    add_preload(12'hFFF, 8'hFF);
    add_instr(bccpu_pkg::OP_LOAD, 8'd11, 8'd0, 8'd0);
    add_instr(bccpu_pkg::OP_MULI, 8'd12, 8'd1, 8'd16);
    add_instr(bccpu_pkg::OP_ADDI, 8'd12, 8'd12, 8'd12);
    add_instr(bccpu_pkg::OP_STORE, 8'd12, 8'd4, 8'd0);
    add_instr(bccpu_pkg::OP_LOAD, 8'd13, 8'd12, 8'd0);
    add_instr(bccpu_pkg::OP_ADDI, 8'd14, 8'd12, 8'd1);
    add_instr(bccpu_pkg::OP_LOAD, 8'd15, 8'd14, 8'd0);
    add_instr(bccpu_pkg::OP_STORE, 8'd4, 8'd1, 8'd0);
    add_instr(8'h08, 8'd0, 8'd0, 8'd3);
    add_instr(bccpu_pkg::OP_BAL, 8'd255, 8'd255, 8'hFE);
    add_drain();

    // random: mostly well-formed ops on a small register window
    for (int i = 0; i < 1320; i++) begin
      it = rand_fields();
      k = $urandom_range(0, 99);
      base = $urandom_range(0, 15);
      if (k < 20) begin
        it.act = 1;
        if ($urandom_range(0, 3) != 0) it.la = 12'($urandom_range(0, 260));
      end else if (k < 35) begin
        add_instr(bccpu_pkg::OP_MOVI, 8'(base), 8'($urandom), 8'($urandom_range(0, 252)));
        i++;
        it.op = ($urandom_range(0, 1) == 0) ? bccpu_pkg::OP_LOAD : bccpu_pkg::OP_STORE;
        if (it.op == bccpu_pkg::OP_LOAD) it.s1 = 8'(base);
        else it.d = 8'(base);
        it.s1 = (it.op == bccpu_pkg::OP_LOAD) ? 8'(base) : 8'($urandom_range(0, 15));
        if (it.op == bccpu_pkg::OP_LOAD) it.d = 8'($urandom_range(0, 15));
      end else if (k < 92) begin
        case ($urandom_range(0, 18))
          0: it.op = bccpu_pkg::OP_ADD;
          1: it.op = bccpu_pkg::OP_SUB;
          2: it.op = bccpu_pkg::OP_MUL;
          3: it.op = bccpu_pkg::OP_DIV;
          4: it.op = bccpu_pkg::OP_LOAD;
          5: it.op = bccpu_pkg::OP_STORE;
          6: it.op = bccpu_pkg::OP_MOV;
          7: it.op = bccpu_pkg::OP_ADDI;
          8: it.op = bccpu_pkg::OP_SUBI;
          9: it.op = bccpu_pkg::OP_MULI;
          10: it.op = bccpu_pkg::OP_DIVI;
          11: it.op = bccpu_pkg::OP_MOVI;
          12: it.op = bccpu_pkg::OP_BEQ;
          13: it.op = bccpu_pkg::OP_BNE;
          14: it.op = bccpu_pkg::OP_BGE;
          15: it.op = bccpu_pkg::OP_BLT;
          16: it.op = bccpu_pkg::OP_BGT;
          17: it.op = bccpu_pkg::OP_BLE;
          default: it.op = bccpu_pkg::OP_BAL;
        endcase
        if ($urandom_range(0, 7) != 0) begin
          it.d = 8'($urandom_range(0, 15));
          it.s1 = 8'($urandom_range(0, 15));
          if (it.op inside {bccpu_pkg::OP_ADD, bccpu_pkg::OP_SUB,
                            bccpu_pkg::OP_MUL, bccpu_pkg::OP_DIV})
            it.s2 = 8'($urandom_range(0, 15));
        end
      end else begin
        // unknown opcode noise, halt kept for the end
        if (it.op == bccpu_pkg::OP_HALT) it.op = 8'hFF;
      end
      pending_instrs.push_back(it);
      if (i == 700) add_drain();
    end

    // halt, then items that must change nothing
    add_instr(bccpu_pkg::OP_HALT, 8'($urandom), 8'($urandom), 8'($urandom));
    for (int i = 0; i < 12; i++) begin
      if (i % 3 == 0) add_preload(12'($urandom_range(0, 15)), 8'($urandom));
      else add_instr(bccpu_pkg::OP_MOVI, 8'($urandom_range(0, 15)), 8'd0, 8'($urandom));
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (pending_instrs.size() > 0 || s_tvalid || expected_results.size() > 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("byte_coded_cpu_execute_unit verification clean");
    end else begin
      $display("byte_coded_cpu_execute_unit verification failed");
    end
    $finish;
  end

endmodule
